// ----- hw/rtl/kcl_pkg.sv -----
// ============================================================================
// kcl_pkg - keypad code lock shared types and constants
// Key codes, outcome codes, register map and the structs between modules.
// ============================================================================
package kcl_pkg;

    // key codes (row*3 + col + 1); codes 1..9 are the digits themselves
    localparam logic [3:0] KEY_BACKSPACE = 4'd10;
    localparam logic [3:0] KEY_ZERO      = 4'd11;
    localparam logic [3:0] KEY_ENTER     = 4'd12;

    // column code that is not a key
    localparam logic [1:0] COL_NONE = 2'd3;

    // digits held by the secret register
    localparam int SECRET_DIGITS = 10;

    // configuration port
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 64;

    localparam logic REG_CODE_LENGTH = 1'b0;
    localparam logic REG_CODE_DIGITS = 1'b1;

    localparam logic [3:0]  CODE_LENGTH_RESET = 4'd4;
    localparam logic [39:0] CODE_DIGITS_RESET = 40'h11_11;

    typedef enum logic [1:0] {
        OUT_CONTINUE = 2'd0,
        OUT_ACCEPT   = 2'd1,
        OUT_REJECT   = 2'd2
    } outcome_t;

    typedef struct packed {
        logic [3:0]  code_length;
        logic [39:0] code_digits;
    } cfg_t;

    typedef struct packed {
        logic [3:0] entered_count;
        outcome_t   outcome;
    } result_t;

endpackage

// ----- hw/rtl/keypad_code_lock_core.sv -----
// ============================================================================
// keypad_code_lock_core - keypad combination lock
// Takes key presses from a 4x3 keypad and reports digit count and verdict.
// ============================================================================
//
// Usage:
//   Slave channel (s_*): one transaction per key press, key row and column.
//   Master channel (m_*): one transaction per press, with the digit count
//   held after the press and the outcome (continue / accepted / rejected).
//   APB-style port: code length at byte address 0, secret digits at 8.
//   Write configuration only while no press is in flight.
//
// Pipeline: input register, then result register.  Throughput: one press
// per cycle while m_tready stays high; the whole press (decode, entry
// update, ten-digit compare) is one combinational pass between the two
// registers.
//
// Reset: entry emptied, code length 4, secret code 1111, both channels
// empty.  The entry digit store itself is not reset.
//
// Receiver stall: the result register holds; the input register still
// takes one more press, then s_tready drops until m_tready returns.
//
module keypad_code_lock_core #(
    parameter int MAX_DIGITS = 10
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    // key press stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [1:0] key_row, [3:2] key_col

    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // [3:0] entered_count, [5:4] outcome

    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [kcl_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [kcl_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [kcl_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready
);

    kcl_pkg::cfg_t    cfg;
    kcl_pkg::result_t result;

    // input register
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [1:0] in_row_reg;
    logic [1:0] in_col_reg;

    // result register
    logic             out_valid_reg;
    logic             out_valid_next;
    kcl_pkg::result_t out_result_reg;

    logic s_accept;
    logic advance;

    // press moves on whenever the result register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_row_reg <= s_tdata[1:0];
            in_col_reg <= s_tdata[3:2];
        end
        if (advance) begin
            out_result_reg <= result;
        end
    end

    kcl_cfg_regs u_cfg_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    kcl_entry #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_entry (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .key_row (in_row_reg),
        .key_col (in_col_reg),
        .cfg     (cfg),
        .result  (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_result_reg.outcome, out_result_reg.entered_count};

endmodule

// ----- hw/rtl/kcl_cfg_regs.sv -----
// ============================================================================
// kcl_cfg_regs - configuration register file
// APB-style slave holding the code length and the secret code digits.
// ============================================================================
module kcl_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [kcl_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [kcl_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [kcl_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready,
    output kcl_pkg::cfg_t                   cfg
);

    kcl_pkg::cfg_t cfg_reg;
    kcl_pkg::cfg_t cfg_next;
    logic          wr_en;
    logic          reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    // registers sit 8 bytes apart
    assign reg_sel = paddr[3];

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_sel)
                kcl_pkg::REG_CODE_LENGTH: cfg_next.code_length = pwdata[3:0];
                kcl_pkg::REG_CODE_DIGITS: cfg_next.code_digits = pwdata[39:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.code_length <= kcl_pkg::CODE_LENGTH_RESET;
            cfg_reg.code_digits <= kcl_pkg::CODE_DIGITS_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (reg_sel)
            kcl_pkg::REG_CODE_LENGTH: prdata = {60'd0, cfg_reg.code_length};
            kcl_pkg::REG_CODE_DIGITS: prdata = {24'd0, cfg_reg.code_digits};
            default: prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ----- hw/rtl/kcl_entry.sv -----
// ============================================================================
// kcl_entry - entry buffer, digit count and code compare
// Applies one key press per step and produces that press's result.
// ============================================================================
module kcl_entry #(
    parameter int MAX_DIGITS = 10
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  logic [1:0]         key_row,
    input  logic [1:0]         key_col,
    input  kcl_pkg::cfg_t      cfg,
    output kcl_pkg::result_t   result
);

    localparam int CW   = $clog2(MAX_DIGITS + 1);
    localparam int CMPW = (CW > 4) ? CW : 4;

    logic [3:0] entry_reg [MAX_DIGITS];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    logic [3:0]            key;
    logic                  key_valid;
    logic                  is_digit;
    logic                  is_back;
    logic                  is_enter;
    logic [3:0]            digit;
    logic                  wr_en;
    logic [3:0]            secret [MAX_DIGITS];
    logic [MAX_DIGITS-1:0] digit_ok;
    logic                  match;

    // key decode
    assign key       = ({2'b00, key_row} * 4'd3) + {2'b00, key_col} + 4'd1;
    assign key_valid = (key_col != kcl_pkg::COL_NONE);

    always_comb begin
        is_digit = 1'b0;
        is_back  = 1'b0;
        is_enter = 1'b0;
        digit    = key;
        case (key)
            kcl_pkg::KEY_BACKSPACE: is_back  = key_valid;
            kcl_pkg::KEY_ENTER:     is_enter = key_valid;
            kcl_pkg::KEY_ZERO: begin
                is_digit = key_valid;
                digit    = 4'd0;
            end
            default: is_digit = key_valid;
        endcase
    end

    // secret digits past the register read as zero
    for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_secret
        if (g < kcl_pkg::SECRET_DIGITS) begin : g_reg
            assign secret[g] = cfg.code_digits[4*g +: 4];
        end else begin : g_zero
            assign secret[g] = 4'd0;
        end
    end

    // parallel compare, digits at or above the count don't care
    always_comb begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            digit_ok[i] = (CW'(i) >= count_reg) || (entry_reg[i] == secret[i]);
        end
    end

    assign match = (CMPW'(count_reg) == CMPW'(cfg.code_length)) && (&digit_ok);

    assign wr_en = step && is_digit && (CMPW'(count_reg) < CMPW'(MAX_DIGITS));

    always_comb begin
        count_next = count_reg;
        if (step) begin
            if (wr_en) begin
                count_next = count_reg + CW'(1);
            end else if (is_back && (count_reg != '0)) begin
                count_next = count_reg - CW'(1);
            end else if (is_enter) begin
                count_next = '0;
            end
        end
    end

    always_comb begin
        result.entered_count = 4'(count_next);
        if (is_enter) begin
            result.outcome = match ? kcl_pkg::OUT_ACCEPT : kcl_pkg::OUT_REJECT;
        end else begin
            result.outcome = kcl_pkg::OUT_CONTINUE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // entry store: no reset, only slots below the count are ever compared
    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (wr_en && (CW'(i) == count_reg)) begin
                entry_reg[i] <= digit;
            end
        end
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        CMPW'(count_reg) <= CMPW'(MAX_DIGITS))
        else $error("entry count beyond capacity");

    a_enter_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        step && is_enter |=> count_reg == '0)
        else $error("enter did not clear the entry");

    a_outcome_only_on_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        step && (result.outcome != kcl_pkg::OUT_CONTINUE) |-> is_enter)
        else $error("verdict without enter key");

    a_hold_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> $stable(count_reg))
        else $error("entry count moved without a key press");

    a_digit_appends: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> count_reg == $past(count_reg) + CW'(1))
        else $error("digit press did not extend the entry");

endmodule

// ----- tb/keypad_code_lock_core_tb.sv -----
// ----------------------------------------------------------------------------
// keypad_code_lock_core_tb - self-checking bench for the keypad code lock
// Drives key presses through the stream input and checks every result against
// an in-bench model of the entry buffer and code compare. The secret code is
// reprogrammed between phases and both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module keypad_code_lock_core_tb;

    localparam int MAX_DIGITS     = 10;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_PRESSES  = 200;   // counted presses per random phase
    localparam int PRESSURE_PHASE = 4;     // phase with the long receiver hold
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 6;     // covers the input and result registers
    localparam int REPORT_LIMIT   = 10;

    // register map: byte address 8*index, registers are up to 40 bits wide
    localparam logic [kcl_pkg::CFG_ADDR_W-1:0] ADDR_CODE_LENGTH =
        {kcl_pkg::REG_CODE_LENGTH, 3'b000};
    localparam logic [kcl_pkg::CFG_ADDR_W-1:0] ADDR_CODE_DIGITS =
        {kcl_pkg::REG_CODE_DIGITS, 3'b000};

    // one key press as it sits in s_tdata: row in the low bits, column above
    typedef struct packed {
        logic [1:0] col;
        logic [1:0] row;
    } key_press_t;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [7:0]                     s_tdata  = '0;   // [1:0] key_row, [3:2] key_col
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [7:0]                     m_tdata;         // [3:0] entered_count, [5:4] outcome
    logic                           psel     = 1'b0;
    logic                           penable  = 1'b0;
    logic                           pwrite   = 1'b0;
    logic [kcl_pkg::CFG_ADDR_W-1:0] paddr    = '0;
    logic [kcl_pkg::CFG_DATA_W-1:0] pwdata   = '0;
    logic [kcl_pkg::CFG_DATA_W-1:0] prdata;
    logic                           pready;

    // presses waiting to be offered, and verdicts owed by the block
    key_press_t        key_presses[$];
    kcl_pkg::result_t  pending_verdicts[$];
    kcl_pkg::result_t  next_verdict;

    // bench copy of the lock: entry buffer, digit count and secret code
    logic [3:0]  entry_store[MAX_DIGITS];
    logic [3:0]  entry_len;
    logic [3:0]  secret_length;
    logic [39:0] secret_code;

    // traffic shaping, set per phase by the stimulus process
    int unsigned sender_idle_pct    = 0;
    int unsigned receiver_stall_pct = 0;
    bit          pressure_on        = 1'b0;
    int unsigned hold_cycles;

    int unsigned error_count = 0;
    int unsigned press_count = 0;   // presses that are real keys

    keypad_code_lock_core #(
        .MAX_DIGITS (MAX_DIGITS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Lock model
    // ------------------------------------------------------------------

    // the entry opens only on an exact length and every digit equal
    function automatic bit entry_opens_lock();
        if (entry_len != secret_length)
            return 1'b0;
        for (int i = 0; i < entry_len; i++)
            if (entry_store[i] != secret_code[4*i +: 4])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic kcl_pkg::result_t apply_key_press(input key_press_t p);
        logic [3:0]       code;
        kcl_pkg::result_t verdict;
        verdict.outcome = kcl_pkg::OUT_CONTINUE;
        // column three is no key at all: nothing changes
        if (p.col != kcl_pkg::COL_NONE) begin
            code = 4'(p.row) * 4'd3 + 4'(p.col) + 4'd1;
            if (code == kcl_pkg::KEY_BACKSPACE) begin
                if (entry_len != 0)
                    entry_len = entry_len - 4'd1;
            end else if (code == kcl_pkg::KEY_ENTER) begin
                verdict.outcome = entry_opens_lock() ? kcl_pkg::OUT_ACCEPT
                                                     : kcl_pkg::OUT_REJECT;
                entry_len = '0;
            end else if (entry_len < MAX_DIGITS) begin
                // digit keys on a full entry fall through here and are dropped
                entry_store[entry_len] = (code == kcl_pkg::KEY_ZERO) ? 4'd0 : code;
                entry_len = entry_len + 4'd1;
            end
        end
        verdict.entered_count = entry_len;
        return verdict;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers queued presses, models each accepted transaction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                pending_verdicts.push_back(apply_key_press(key_press_t'(s_tdata[3:0])));
            if (!s_tvalid || s_tready) begin
                if (key_presses.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    s_tdata  <= {4'b0000, key_presses.pop_front()};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver ready: random stalls, plus one long hold counted here
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready    <= 1'b0;
            hold_cycles <= 0;
        end else begin
            hold_cycles <= pressure_on ? hold_cycles + 1 : 0;
            if (pressure_on && hold_cycles < HOLD_CYCLES)
                m_tready <= 1'b0;
            else
                m_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: each result transaction against the oldest verdict owed
    // ------------------------------------------------------------------
    function automatic void flag_error(input string what, input int want, input int got);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("ERROR %s: expected %0d, got %0d", what, want, got);
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_verdicts.size() == 0) begin
                flag_error("result with nothing owed, m_tdata", 0, int'(m_tdata));
            end else begin
                next_verdict = pending_verdicts.pop_front();
                if (m_tdata[3:0] != next_verdict.entered_count)
                    flag_error("entered_count", int'(next_verdict.entered_count),
                               int'(m_tdata[3:0]));
                if (m_tdata[5:4] != next_verdict.outcome)
                    flag_error("outcome", int'(next_verdict.outcome),
                               int'(m_tdata[5:4]));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic key_press_t press_of(input logic [3:0] code);
        key_press_t p;
        p.row = 2'((code - 4'd1) / 4'd3);
        p.col = 2'((code - 4'd1) % 4'd3);
        return p;
    endfunction

    function automatic void queue_press(input key_press_t p);
        key_presses.push_back(p);
        if (p.col != kcl_pkg::COL_NONE)
            press_count++;
    endfunction

    function automatic void queue_digit(input logic [3:0] digit);
        queue_press(press_of(digit == 4'd0 ? kcl_pkg::KEY_ZERO : digit));
    endfunction

    function automatic void queue_noise(input int n);
        key_press_t p;
        for (int i = 0; i < n; i++) begin
            p.row = 2'($urandom_range(3));
            p.col = 2'($urandom_range(3));
            queue_press(p);
        end
    endfunction

    // one try at the lock: mostly the right code, sometimes off by a digit,
    // a wrong length, a slip corrected with backspace, or overflowing entry
    function automatic void queue_attempt();
        int         len;
        logic [3:0] digit;
        len = ($urandom_range(99) < 65) ? int'(secret_length) : $urandom_range(12);
        for (int i = 0; i < len; i++) begin
            digit = (i < MAX_DIGITS) ? secret_code[4*i +: 4] : 4'($urandom_range(9));
            if (digit > 4'd9 || $urandom_range(24) == 0)
                digit = 4'($urandom_range(9));
            if ($urandom_range(11) == 0) begin
                queue_digit(4'($urandom_range(9)));
                queue_press(press_of(kcl_pkg::KEY_BACKSPACE));
            end
            queue_digit(digit);
        end
        if ($urandom_range(14) == 0)
            queue_noise(1);
        queue_press(press_of(kcl_pkg::KEY_ENTER));
    endfunction

    function automatic logic [39:0] decimal_code();
        logic [39:0] code;
        for (int i = 0; i < 10; i++)
            code[4*i +: 4] = 4'($urandom_range(9));
        return code;
    endfunction

    // APB write: setup cycle, then access cycle; pready is always high
    task automatic write_register(input logic [kcl_pkg::CFG_ADDR_W-1:0] addr,
                                  input logic [kcl_pkg::CFG_DATA_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic program_lock(input logic [3:0] len, input logic [39:0] code);
        write_register(ADDR_CODE_LENGTH, kcl_pkg::CFG_DATA_W'(len));
        write_register(ADDR_CODE_DIGITS, kcl_pkg::CFG_DATA_W'(code));
        secret_length = len;
        secret_code   = code;
    endtask

    // idle means nothing queued, nothing offered and no verdict owed
    task automatic wait_idle();
        do
            @(negedge aclk);
        while (key_presses.size() != 0 || s_tvalid || pending_verdicts.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        logic [3:0]  len;
        logic [39:0] code;
        int          target;

        entry_len     = '0;
        secret_length = kcl_pkg::CODE_LENGTH_RESET;
        secret_code   = kcl_pkg::CODE_DIGITS_RESET;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset code 1111, every key and the corner cases
        @(negedge aclk);
        queue_press(press_of(kcl_pkg::KEY_BACKSPACE));  // backspace on an empty entry
        queue_press(press_of(kcl_pkg::KEY_ENTER));      // empty entry against length 4
        for (int i = 0; i < 4; i++)
            queue_digit(4'd1);
        queue_press(press_of(kcl_pkg::KEY_ENTER));      // right code
        for (int r = 0; r < 4; r++)
            queue_press('{col: kcl_pkg::COL_NONE, row: 2'(r)});  // column three, no key
        for (int d = 1; d <= 10; d++)
            queue_digit(4'(d % 10));            // every digit, fills the entry
        queue_digit(4'd5);                      // digit on a full entry
        queue_press(press_of(kcl_pkg::KEY_BACKSPACE));
        queue_press(press_of(kcl_pkg::KEY_ENTER));

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_idle();
            code = decimal_code();
            case (ph)
                0: len = 4'd0;                                  // empty code
                1: len = 4'd10;                                 // full-length code
                2: begin                                        // all extremes
                    len  = 4'd15;
                    code = 40'hFF_FFFF_FFFF;
                end
                3: begin
                    len  = 4'd1;
                    code = '0;
                end
                4: len = 4'd10;
                5: begin                                        // one digit above nine
                    len = 4'($urandom_range(9, 1));
                    code[4*$urandom_range(len - 1) +: 4] = 4'($urandom_range(15, 10));
                end
                6: len = 4'($urandom_range(15, 11));            // beyond capacity
                default: begin
                    len  = 4'($urandom_range(9, 2));
                    code = {8'($urandom), 32'($urandom)};
                end
            endcase
            program_lock(len, code);

            @(negedge aclk);
            case (ph % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 84; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 84; end
                default: begin sender_idle_pct = 11; receiver_stall_pct = 11; end
            endcase
            // the receiver holds off while the sender streams: block fills up
            pressure_on = (ph == PRESSURE_PHASE);

            target = press_count + PHASE_PRESSES;
            while (press_count < target) begin
                if ($urandom_range(99) < 80)
                    queue_attempt();
                else
                    queue_noise($urandom_range(6, 1));
            end
        end

        wait_idle();
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/kcl_pkg.sv
hw/rtl/kcl_cfg_regs.sv
hw/rtl/kcl_entry.sv
hw/rtl/keypad_code_lock_core.sv
tb/keypad_code_lock_core_tb.sv
